FILE: rtl/core/sorted_list_insert_delete_core_macros.svh
// Assertion helpers for the sorted list core.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list core: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list core: next-cycle check failed");

`endif

FILE: rtl/core/sli_pkg.sv
package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // transaction kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  element;
        logic [1:0]                 status;
        logic [COUNT_W-1:0]         entry_count;
        logic                       last;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op                   op;
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  head;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

endpackage

FILE: rtl/core/sli_cell.sv
module sli_cell (
    input  logic                               i_clk,
    input  sli_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_occ,
    input  logic                               i_right_occ,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_left_val,
    input  logic                               i_left_lt,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_right_val,
    output logic signed [sli_pkg::VALUE_W-1:0] o_val,
    output logic                               o_lt,
    output logic                               o_hit
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    // lt is a prefix of the chain since entries stay sorted
    assign o_lt  = i_occ && (r_val < i_ctl.value);
    // first equal entry sits right at the lt boundary
    assign o_hit = i_occ && (r_val == i_ctl.value) && !o_lt && i_left_lt;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_lt) begin
                    n_val = i_left_lt ? i_ctl.value : i_left_val;
                end
            end
            CELL_DELETE: begin
                if (!o_lt) begin
                    n_val = i_right_val;
                end
            end
            CELL_ROTATE: begin
                if (i_right_occ) begin
                    n_val = i_right_val;
                end else if (i_occ) begin
                    n_val = i_ctl.head;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/core/sorted_list_insert_delete_core.sv
// Sorted list core: keeps up to CAPACITY signed Q16.16 values in ascending order in a chain
// of cells, one value per cell, each cell comparing against the broadcast operand and taking
// its new value from itself or a neighbor. Insert (kind 0) places the value ahead of any equal
// entries, or returns status full when CAPACITY entries are held. Delete (kind 1) removes the
// first equal entry or returns not found. Read (kind 2) returns every entry in order, last set
// on the final one; an empty list gives one transaction with status empty. Any other kind
// returns status ok with no change. Insert, delete and no-op are applied in one shift step
// of the whole chain once accepted; a read of N entries does one rotation of the occupied
// cells per returned entry, so the list is intact when the read ends. Transactions are
// handled one at a time; a new one is accepted while the previous result is still waiting
// in the output register. entry_count reports the count modulo 32.
module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sli_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sli_pkg::t_out_item o_out_data
);
    import sli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_ov, n_ov;
    // latched transaction and output payload
    logic [1:0]                r_kind, n_kind;
    logic signed [VALUE_W-1:0] r_value, n_value;
    t_out_item                 r_out, n_out;

    t_cell_op                  w_op;
    t_cell_ctl                 w_ctl;
    logic signed [VALUE_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]       w_lt;
    logic [CAPACITY-1:0]       w_hit;
    logic [CAPACITY-1:0]       w_occ;
    logic                      w_found;
    logic                      w_out_free;

    // broadcast: operation from the sequencer, operand and head value from registers
    assign w_ctl = {w_op, r_value, w_val[0]};

    // ---------------- cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VALUE_W-1:0] w_left_val;
            logic signed [VALUE_W-1:0] w_right_val;
            logic                      w_left_lt;
            logic                      w_right_occ;

            assign w_occ[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_first
                // head of the chain acts as if everything to its left is smaller
                assign w_left_val = r_value;
                assign w_left_lt  = 1'b1;
            end else begin : g_mid
                assign w_left_val = w_val[gi-1];
                assign w_left_lt  = w_lt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_right_val = w_val[gi];
                assign w_right_occ = 1'b0;
            end else begin : g_inner
                assign w_right_val = w_val[gi+1];
                assign w_right_occ = w_occ[gi+1];
            end

            sli_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[gi]),
                .i_right_occ (w_right_occ),
                .i_left_val  (w_left_val),
                .i_left_lt   (w_left_lt),
                .i_right_val (w_right_val),
                .o_val       (w_val[gi]),
                .o_lt        (w_lt[gi]),
                .o_hit       (w_hit[gi])
            );
        end
    endgenerate

    assign w_found    = |w_hit;
    assign w_out_free = !r_ov || i_out_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_kind   = r_kind;
        n_value  = r_value;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;

        w_op = CELL_HOLD;

        o_in_ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind  = i_in_data.kind;
                    n_value = i_in_data.value;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_ov               = 1'b1;
                    n_out.element      = '0;
                    n_out.status       = STAT_OK;
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                    case (r_kind)
                        KIND_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                w_op    = CELL_INSERT;
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_DELETE: begin
                            if (w_found) begin
                                w_op    = CELL_DELETE;
                                n_count = r_count - 1'b1;
                            end else begin
                                n_out.status = STAT_NOT_FOUND;
                            end
                        end
                        KIND_READ: begin
                            if (r_count == '0) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                // first entry goes out now, rest from ST_READ
                                w_op          = CELL_ROTATE;
                                n_out.element = w_val[0];
                                n_out.last    = (r_count == CW'(1));
                                n_rd_idx      = CW'(1);
                                if (r_count != CW'(1)) begin
                                    n_state = ST_READ;
                                end
                            end
                        end
                        default: begin
                            n_out.status = STAT_OK;
                        end
                    endcase
                    n_out.entry_count = COUNT_W'(n_count);
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_op              = CELL_ROTATE;
                    n_ov              = 1'b1;
                    n_out.element     = w_val[0];
                    n_out.status      = STAT_OK;
                    n_out.entry_count = COUNT_W'(r_count);
                    n_out.last        = (r_rd_idx == CW'(r_count - 1'b1));
                    n_rd_idx          = r_rd_idx + 1'b1;
                    if (n_out.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_out   <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/sli_checker.sv
`include "sorted_list_insert_delete_core_macros.svh"

module sli_checker #(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sli_pkg::t_out_item o_out_data
);
    import sli_pkg::*;

    logic w_out_stall;
    logic w_in_take;
    logic w_full_seen;
    logic w_full_ok;
    logic w_empty_seen;
    logic w_empty_ok;

    assign w_out_stall  = o_out_valid && !i_out_ready;
    assign w_in_take    = i_in_valid && o_in_ready;
    assign w_full_seen  = o_out_valid && (o_out_data.status == STAT_FULL);
    // full only at capacity; entry_count wraps at 32
    assign w_full_ok    = (o_out_data.element == '0) && o_out_data.last
                          && (o_out_data.entry_count == COUNT_W'(CAPACITY));
    assign w_empty_seen = o_out_valid && (o_out_data.status == STAT_EMPTY);
    assign w_empty_ok   = (o_out_data.entry_count == '0) && o_out_data.last;

    // a stalled result holds
    `SLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_out_data))

    // one transaction at a time: ready drops right after an accept
    `SLI_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_take, !o_in_ready)

    // a rejected insert is a single result with no element
    `SLI_ASSERT_NOW(a_full_shape, i_clk, i_rst_n, w_full_seen, w_full_ok)

    // empty read reports zero entries
    `SLI_ASSERT_NOW(a_empty_shape, i_clk, i_rst_n, w_empty_seen, w_empty_ok)

endmodule

bind sorted_list_insert_delete_core sli_checker #(.CAPACITY(CAPACITY)) u_sli_checker (.*);

FILE: dv/sorted_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow of the sorted list and checks every result.
module sorted_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  sli_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sli_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending_count
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] list_vals [CAPACITY];
    int                        list_len;
    t_out_item                 results_due [$];

    task automatic queue_result(input logic signed [VALUE_W-1:0] element,
                                input logic [1:0] status, input logic last);
        t_out_item r;
        r.element     = element;
        r.status      = status;
        r.entry_count = COUNT_W'(list_len);
        r.last        = last;
        results_due.push_back(r);
    endtask

    // Apply one transaction to the shadow list and queue what it should return.
    task automatic update_sorted_list(input t_in_item op);
        logic signed [VALUE_W-1:0] v;
        int pos;
        v = $signed(op.value);
        pos = 0;
        case (op.kind)
            KIND_INSERT: begin
                if (list_len >= CAPACITY) begin
                    queue_result('0, STAT_FULL, 1'b1);
                end else begin
                    // ahead of any equal entries
                    while (pos < list_len && list_vals[pos] < v) pos++;
                    for (int k = list_len; k > pos; k--) list_vals[k] = list_vals[k-1];
                    list_vals[pos] = v;
                    list_len++;
                    queue_result('0, STAT_OK, 1'b1);
                end
            end
            KIND_DELETE: begin
                while (pos < list_len && list_vals[pos] != v) pos++;
                if (pos >= list_len) begin
                    queue_result('0, STAT_NOT_FOUND, 1'b1);
                end else begin
                    for (int k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                    list_len--;
                    queue_result('0, STAT_OK, 1'b1);
                end
            end
            KIND_READ: begin
                if (list_len == 0) begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    for (int k = 0; k < list_len; k++)
                        queue_result(list_vals[k], STAT_OK, k + 1 == list_len);
                end
            end
            default: begin
                queue_result('0, STAT_OK, 1'b1);
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            $error("unexpected result: element %0d status %0d entry_count %0d last %0b",
                   got.element, got.status, got.entry_count, got.last);
            o_fail_count++;
        end else begin
            want = results_due.pop_front();
            if (got.element !== want.element) begin
                $error("element: expected %0d, got %0d", want.element, got.element);
                o_fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                o_fail_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                o_fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                o_fail_count++;
            end
        end
    endtask

    // Results first: a result can never belong to a transaction taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len     = 0;
            o_fail_count = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) update_sorted_list(i_in_data);
        end
        o_pending_count = results_due.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Top of the sorted list testbench: clock, reset, stimulus and verdict.
// All prediction and comparison lives in sorted_list_checker.
module tb;
    import sli_pkg::*;

    // kind 3 has no name in the package; the core must answer it as a no-op
    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_OPS  = 400;
    localparam int QUIET_TAIL  = 60;       // last transactions run with no idling
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 40;       // wait after the drain, in cycles
    localparam int CYCLE_LIMIT = 1_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending_count;
    int cycle_cnt = 0;

    // idling controls, shared between the sender and the receiver process
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit rx_long_hold = 1'b0;

    logic signed [VALUE_W-1:0] inserted_vals [$];  // recent inserts, to aim deletes

    always #5 clk = ~clk;

    sorted_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sorted_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Watchdog: sized from the slowest legal run (16 results per transaction, each
    // behind a receiver stall burst) with plenty of margin on top.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random ready bursts, random stall bursts, and one long hold-off on
    // request so the core backs up into its input.
    initial begin
        @(posedge clk);
        forever begin
            if (rx_long_hold) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_long_hold = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one transaction, optionally after an idle burst. Valid stays high after
    // acceptance; the next call either keeps it up or drops it for a gap.
    task automatic send_item(input logic [1:0] op_kind,
                             input logic signed [VALUE_W-1:0] op_value);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_data.kind  <= op_kind;
        in_data.value <= op_value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Sender pause: nothing offered until every predicted result has come back.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Value mix: extremes, a narrow band of Q16.16 half-steps (duplicates are
    // common there), and full-range noise.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int s;
        s = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(VALUE_W-1){1'b1}}};
            1:       return {1'b1, {(VALUE_W-1){1'b0}}};
            2, 3, 4, 5: return (s - 8) * 32768;
            default: return $urandom;
        endcase
    endfunction

    // Deletes mostly hit something inserted recently so the list actually shrinks.
    function automatic logic signed [VALUE_W-1:0] pick_delete_value();
        if (inserted_vals.size() != 0 && $urandom_range(0, 9) < 7)
            return inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        return pick_value();
    endfunction

    task automatic send_insert(input logic signed [VALUE_W-1:0] v);
        inserted_vals.push_back(v);
        if (inserted_vals.size() > 32) void'(inserted_vals.pop_front());
        send_item(KIND_INSERT, v);
    endtask

    initial begin
        logic [1:0]                op_kind;
        int                        roll;
        int                        s;
        bit                        filling;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // empty store: read gives one empty result, delete misses, no-op keeps count
        send_item(KIND_READ, $urandom);
        send_item(KIND_DELETE, 32'sd0);
        send_item(KIND_NOP, $urandom);
        // extremes, zero, negative, and a duplicate that must land ahead of its twin
        send_insert({1'b0, {(VALUE_W-1){1'b1}}});
        send_insert({1'b1, {(VALUE_W-1){1'b0}}});
        send_insert(32'sd0);
        send_insert(-32'sd1);
        send_insert(32'sd0);
        send_insert(32'sd1);
        send_item(KIND_READ, $urandom);
        send_item(KIND_DELETE, 32'sd0);        // first equal of two
        send_item(KIND_DELETE, 32'sd12345);    // not present
        // fill to capacity with close, repeating values, then overflow
        for (int k = 0; k < 11; k++) begin
            s = $urandom_range(0, 3);
            send_insert((s - 1) * 65536);
        end
        send_insert(32'sh0001_8000);           // rejected: store full
        send_item(KIND_READ, $urandom);        // full readout, 16 results
        send_item(KIND_DELETE, {1'b0, {(VALUE_W-1){1'b1}}});

        // ---- random ----
        // Alternate 40-transaction windows biased toward filling and toward
        // emptying, so the count sweeps between empty and full repeatedly.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS - QUIET_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            // receiver holds off while the sender keeps offering
            if (n == 120) rx_long_hold = 1'b1;
            if (n == 220) wait_results_drained();

            filling = ((n / 40) % 2) == 0;
            roll    = $urandom_range(0, 99);
            if (roll < (filling ? 60 : 25))
                op_kind = KIND_INSERT;
            else if (roll < 85)
                op_kind = KIND_DELETE;
            else if (roll < 97)
                op_kind = KIND_READ;
            else
                op_kind = KIND_NOP;

            case (op_kind)
                KIND_INSERT: send_insert(pick_value());
                KIND_DELETE: send_item(KIND_DELETE, pick_delete_value());
                default:     send_item(op_kind, $urandom);
            endcase
        end

        // ---- wind-down ----
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge clk);   // catch any stray result

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
